/* rtl/core/sle_pkg.sv */
// ----------------------------------------------------------------------------
// sle_pkg
// shared types and codes of the sorted list engine
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

    localparam int ValueW  = 32;
    localparam int CountW  = 5;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_DUMP   = 2'd2;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_DELETED  = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_ELEMENT  = 3'd4,
        ST_EMPTY    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic [1:0]               command;
        logic signed [ValueW-1:0] value;
    } t_in;

    typedef struct packed {
        t_status                  status;
        logic signed [ValueW-1:0] element_value;
        logic                     last;
        logic [CountW-1:0]        count;
    } t_out;

    typedef struct packed {
        t_cell_op                 op;
        logic signed [ValueW-1:0] key;
    } t_ctrl;

endpackage

`default_nettype wire

/* rtl/core/sle_cell.sv */
// ----------------------------------------------------------------------------
// sle_cell
// one slot of the sorted chain: compare against the key, shift left or right
// ----------------------------------------------------------------------------
`default_nettype none

module sle_cell #(
    parameter int CW    = 5,
    parameter int INDEX = 0
) (
    input  wire                               i_clk,
    input  wire sle_pkg::t_ctrl               i_ctrl,
    input  wire [CW-1:0]                      i_count,
    input  wire                               i_left_past,
    input  wire signed [sle_pkg::ValueW-1:0]  i_left_value,
    input  wire signed [sle_pkg::ValueW-1:0]  i_right_value,
    input  wire signed [sle_pkg::ValueW-1:0]  i_head_value,
    output logic                              o_past,
    output logic                              o_hit,
    output logic signed [sle_pkg::ValueW-1:0] o_value
);
    import sle_pkg::*;

    logic signed [ValueW-1:0] r_value;
    logic signed [ValueW-1:0] n_value;
    logic                     valid;
    logic                     tail;

    assign valid   = (CW'(INDEX) < i_count);
    assign tail    = (CW'(INDEX + 1) == i_count);
    assign o_past  = !valid || (r_value >= i_ctrl.key);
    assign o_hit   = o_past && !i_left_past && valid && (r_value == i_ctrl.key);
    assign o_value = r_value;

    always_comb begin
        case (i_ctrl.op)
            CELL_INSERT: begin
                if (i_left_past) begin
                    n_value = i_left_value;
                end else if (o_past) begin
                    n_value = i_ctrl.key;
                end else begin
                    n_value = r_value;
                end
            end
            CELL_DELETE: n_value = o_past ? i_right_value : r_value;
            CELL_ROTATE: n_value = tail ? i_head_value : i_right_value;
            default:     n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

`default_nettype wire

/* rtl/core/sorted_list_engine.sv */
// ----------------------------------------------------------------------------
// sorted_list_engine
// ascending store of up to DEPTH signed values in a chain of compare cells
// ----------------------------------------------------------------------------
// input beats carry a command and a value; output beats carry status,
// element value, last flag and count. both channels use valid and ready.
// insert and delete are settled by all cells in parallel in the cycle the
// beat is taken; the result is registered and appears in the next cycle, and
// the next command is taken in that same cycle if the output is free.
// a dump first sets the dump flag, then loads the head cell into the output
// register, one element per cycle while the output is free, DEPTH at most,
// by rotating the occupied cells through the head cell; no new command is
// taken until the last element is loaded.
// an empty dump, a full insert and a missing key give one beat each.
// command 3 is taken and gives no beat.
// a stalled receiver holds the output register and the dump pointer; input
// is refused while the output register is held.
// reset clears the count, the dump state and the output valid; cell
// contents are not cleared and are only ever read below the count.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_engine #(
    parameter int DEPTH = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire sle_pkg::t_in   i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output sle_pkg::t_out       o_out_data
);
    import sle_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    t_ctrl                    ctrl;
    logic [DEPTH-1:0]         past;
    logic [DEPTH-1:0]         hit;
    logic signed [ValueW-1:0] cell_value [DEPTH];

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_left, n_left;
    logic          r_dump, n_dump;
    logic          r_out_valid, n_out_valid;
    t_out          r_out, n_out;

    logic              take;
    logic              out_free;
    logic              full;
    logic              found;
    logic [CW+4:0]     count_ext;
    logic [CountW-1:0] count_field;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_dump && out_free;
    assign take        = i_in_valid && o_in_ready;
    assign full        = (r_count == CW'(DEPTH));
    assign found       = |hit;
    assign count_ext   = {5'd0, n_count};
    assign count_field = count_ext[CountW-1:0];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        sle_cell #(
            .CW    (CW),
            .INDEX (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_count       (r_count),
            .i_left_past   ((g == 0) ? 1'b0 : past[(g == 0) ? 0 : g - 1]),
            .i_left_value  ((g == 0) ? ctrl.key : cell_value[(g == 0) ? 0 : g - 1]),
            .i_right_value (cell_value[(g == DEPTH - 1) ? g : g + 1]),
            .i_head_value  (cell_value[0]),
            .o_past        (past[g]),
            .o_hit         (hit[g]),
            .o_value       (cell_value[g])
        );
    end

    always_comb begin
        ctrl.key = i_in_data.value;
        ctrl.op  = CELL_HOLD;
        if (take) begin
            case (i_in_data.command)
                CMD_INSERT: ctrl.op = full ? CELL_HOLD : CELL_INSERT;
                CMD_DELETE: ctrl.op = found ? CELL_DELETE : CELL_HOLD;
                default:    ctrl.op = CELL_HOLD;
            endcase
        end else if (r_dump && out_free) begin
            ctrl.op = CELL_ROTATE;
        end
    end

    always_comb begin
        n_count     = r_count;
        n_left      = r_left;
        n_dump      = r_dump;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (take) begin
            n_out.element_value = '0;
            n_out.last          = 1'b1;
            case (i_in_data.command)
                CMD_INSERT: begin
                    n_out_valid = 1'b1;
                    if (full) begin
                        n_out.status = ST_FULL;
                    end else begin
                        n_out.status = ST_INSERTED;
                        n_count      = r_count + CW'(1);
                    end
                end
                CMD_DELETE: begin
                    n_out_valid = 1'b1;
                    if (found) begin
                        n_out.status = ST_DELETED;
                        n_count      = r_count - CW'(1);
                    end else begin
                        n_out.status = ST_NOTFOUND;
                    end
                end
                CMD_DUMP: begin
                    if (r_count == '0) begin
                        n_out_valid  = 1'b1;
                        n_out.status = ST_EMPTY;
                    end else begin
                        n_dump = 1'b1;
                        n_left = r_count;
                    end
                end
                default: begin
                end
            endcase
        end else if (r_dump && out_free) begin
            n_out_valid         = 1'b1;
            n_out.status        = ST_ELEMENT;
            n_out.element_value = cell_value[0];
            n_out.last          = (r_left == CW'(1));
            n_left              = r_left - CW'(1);
            n_dump              = (r_left != CW'(1));
        end
        n_out.count = count_field;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_left      <= '0;
            r_dump      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_left      <= n_left;
            r_dump      <= n_dump;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* bench/tb_sorted_list_engine.sv */
// ----------------------------------------------------------------------------
// tb_sorted_list_engine
// self-checking bench for the sorted list engine
// ----------------------------------------------------------------------------
// a scoreboard class keeps its own ascending store and count, predicts the
// beats of every accepted command and checks each output beat in order.
// a directed run covers empty and full stores, equal values, extreme values,
// missing keys and the unused command code; a random run follows with
// fill, drain and mixed bursts, random sender gaps, a receiver that stalls
// on changing patterns, and one long receiver hold-off that backs up input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sorted_list_engine;

    import sle_pkg::*;

    localparam int DEPTH         = 16;
    localparam int RANDOM_ITEMS  = 245;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 400000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    class list_scoreboard;
        logic signed [ValueW-1:0] cells [DEPTH];
        int                       fill;
        t_out                     expected_q [$];
        int                       errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function void push_result(t_status status, logic signed [ValueW-1:0] val,
                                  logic last);
            t_out r;
            r.status        = status;
            r.element_value = val;
            r.last          = last;
            r.count         = fill[CountW-1:0];
            expected_q.push_back(r);
        endfunction

        function void note_input(t_in beat);
            logic signed [ValueW-1:0] key;
            int                       pos;
            key = beat.value;
            case (beat.command)
                CMD_INSERT: begin
                    if (fill >= DEPTH) begin
                        push_result(ST_FULL, '0, 1'b1);
                    end else begin
                        pos = fill;
                        for (int i = 0; i < fill; i++) begin
                            if (cells[i] >= key) begin
                                pos = i;
                                break;
                            end
                        end
                        for (int i = fill; i > pos; i--) cells[i] = cells[i-1];
                        cells[pos] = key;
                        fill++;
                        push_result(ST_INSERTED, '0, 1'b1);
                    end
                end
                CMD_DELETE: begin
                    pos = -1;
                    for (int i = 0; i < fill; i++) begin
                        if (cells[i] == key) begin
                            pos = i;
                            break;
                        end
                    end
                    if (pos < 0) begin
                        push_result(ST_NOTFOUND, '0, 1'b1);
                    end else begin
                        for (int i = pos; i + 1 < fill; i++) cells[i] = cells[i+1];
                        fill--;
                        push_result(ST_DELETED, '0, 1'b1);
                    end
                end
                CMD_DUMP: begin
                    if (fill == 0) begin
                        push_result(ST_EMPTY, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < fill; i++)
                            push_result(ST_ELEMENT, cells[i], i + 1 == fill);
                    end
                end
                default: ;
            endcase
        endfunction

        function logic signed [ValueW-1:0] pick_stored();
            return cells[$urandom_range(0, fill - 1)];
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
            errors++;
        endtask

        task check_result(t_out got);
            t_out want;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected beat, status", got.status, -1);
            end else begin
                want = expected_q.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.element_value !== want.element_value)
                    report_mismatch("element_value", got.element_value,
                                    want.element_value);
                if (got.last !== want.last)
                    report_mismatch("last", got.last, want.last);
                if (got.count !== want.count)
                    report_mismatch("count", got.count, want.count);
            end
        endtask
    endclass

    logic   i_clk;
    logic   i_rst_n;
    logic   in_valid;
    logic   in_ready;
    t_in    in_data;
    logic   out_valid;
    logic   out_ready;
    t_out   out_data;

    bit     hold_request;
    int     cycle_count;

    list_scoreboard sb = new();

    sorted_list_engine #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[sorted_list_engine] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) sb.check_result(out_data);
    end

    task automatic send_beat(t_in beat);
        @(negedge i_clk);
        in_valid = 1'b1;
        in_data  = beat;
        do @(posedge i_clk); while (!in_ready);
        sb.note_input(beat);
    endtask

    function automatic t_in make_beat(logic [1:0] cmd, logic signed [ValueW-1:0] val);
        t_in b;
        b.command = cmd;
        b.value   = val;
        return b;
    endfunction

    task automatic idle_cycles(int n);
        @(negedge i_clk);
        in_valid = 1'b0;
        in_data  = make_beat(2'($urandom), $urandom);
        repeat (n - 1) @(negedge i_clk);
    endtask

    function automatic logic signed [ValueW-1:0] rand_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $signed($urandom_range(0, 15)) - 8;
            4: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 0;
                    default: return -1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in make_item(int bias);
        int          roll;
        int          ins_w;
        int          del_w;
        logic [1:0]  cmd;
        logic signed [ValueW-1:0] val;
        roll  = $urandom_range(0, 99);
        ins_w = (bias == 0) ? 70 : (bias == 1) ? 20 : 45;
        del_w = (bias == 0) ? 15 : (bias == 1) ? 65 : 38;
        val   = rand_value();
        if (roll < ins_w) cmd = CMD_INSERT;
        else if (roll < ins_w + del_w) cmd = CMD_DELETE;
        else if (roll < 96) cmd = CMD_DUMP;
        else cmd = CMD_UNUSED;
        if (cmd == CMD_DELETE && sb.fill > 0 && $urandom_range(0, 9) < 7)
            val = sb.pick_stored();
        return make_beat(cmd, val);
    endfunction

    initial begin
        int  mode;
        bit  hold_served;
        hold_served = 1'b0;
        out_ready   = 1'b0;
        wait (i_rst_n);
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(16, 80)) begin
                @(negedge i_clk);
                if (hold_request && !hold_served) begin
                    hold_served = 1'b1;
                    out_ready   = 1'b0;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                end
                case (mode)
                    0: out_ready = 1'b1;
                    1: out_ready = $urandom_range(0, 1);
                    2: out_ready = (cycle_count % 4) != 0;
                    default: out_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        int  n_random;
        int  burst;
        int  bias;
        t_in item;

        cycle_count  = 0;
        hold_request = 1'b0;
        i_rst_n      = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_beat(make_beat(CMD_DUMP, 32'sd0));
        send_beat(make_beat(CMD_DELETE, 32'sd3));
        send_beat(make_beat(CMD_INSERT, 32'sd0));
        send_beat(make_beat(CMD_INSERT, 32'sh7fff_ffff));
        send_beat(make_beat(CMD_INSERT, 32'sh8000_0000));
        send_beat(make_beat(CMD_INSERT, -32'sd1));
        send_beat(make_beat(CMD_INSERT, 32'sd5));
        send_beat(make_beat(CMD_INSERT, 32'sd5));
        send_beat(make_beat(CMD_DUMP, 32'sh5555_aaaa));
        send_beat(make_beat(CMD_DELETE, 32'sd5));
        send_beat(make_beat(CMD_DELETE, 32'sd7));
        send_beat(make_beat(CMD_UNUSED, 32'sh7fff_ffff));
        send_beat(make_beat(CMD_DUMP, 32'sd0));
        while (sb.fill < DEPTH) send_beat(make_beat(CMD_INSERT, $urandom));
        send_beat(make_beat(CMD_INSERT, 32'sh8000_0000));
        send_beat(make_beat(CMD_DUMP, 32'sd0));
        send_beat(make_beat(CMD_DELETE, 32'sh8000_0000));
        send_beat(make_beat(CMD_DELETE, 32'sh7fff_ffff));

        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            bias  = $urandom_range(0, 2);
            burst = $urandom_range(1, 12);
            if (n_random > 80) hold_request = 1'b1;
            repeat (burst) begin
                item = make_item(bias);
                send_beat(item);
                if (item.command != CMD_UNUSED) n_random++;
            end
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
        end

        @(negedge i_clk);
        in_valid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("[sorted_list_engine] OK");
        end else begin
            $display("[sorted_list_engine] ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/sle_pkg.sv
rtl/core/sle_cell.sv
rtl/core/sorted_list_engine.sv
bench/tb_sorted_list_engine.sv
